/* sv/ttt_pkg.sv */
// Package for the task tick timer table: table sizes, command codes,
// task state codes and adder operation codes. No dependencies.
package ttt_pkg;

  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned PER_W    = 31;
  localparam int unsigned CD_W     = 32;

  localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DALL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DONE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TERM = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RES  = 3'd5;

  localparam logic [1:0] TS_READY   = 2'd0;
  localparam logic [1:0] TS_BLOCKED = 2'd1;
  localparam logic [1:0] TS_TERM    = 2'd2;

  typedef enum logic [1:0] {
    ALU_DEC,
    ALU_INC,
    ALU_SUB,
    ALU_NEG
  } alu_op_e;

endpackage

/* sv/task_tick_timer_table.sv */
// Task tick timer table: command sequencer, task table and one shared 33-bit adder.
// Depends on ttt_pkg.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------------------
//  in      | in_valid_i  | in_stall_o  | mode_i task_handle_i task_index_i period_i
//          |             |             | delay_ms_i
//  out     | out_valid_o | out_stall_i | kind_o status_o task_id_o last_o
//
// Tick, add and delay all scan the used table entries one per cycle (tick and delay
// through the shared adder); a tick step is held while a fire result waits on a
// stalled output. Delay one, terminate and resume touch a single entry, and an unknown
// mode goes straight to an error status. A duplicate handle ends the add scan early.
// Reset clears the task count and control state; table entries hold no reset.
// A new request is taken once the sequencer is back in idle, even while the
// last result still waits in the output register.
module task_tick_timer_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ttt_pkg::MODE_W-1:0]   mode_i,
  input  logic [ttt_pkg::HANDLE_W-1:0] task_handle_i,
  input  logic [ttt_pkg::ID_W-1:0]     task_index_i,
  input  logic [ttt_pkg::PER_W-1:0]    period_i,
  input  logic [ttt_pkg::PER_W-1:0]    delay_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic                         status_o,
  output logic [ttt_pkg::ID_W-1:0]     task_id_o,
  output logic                         last_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_DUP   = 3'd3;
  localparam logic [2:0] S_DLY   = 3'd4;
  localparam logic [2:0] S_ONE   = 3'd5;
  localparam logic [2:0] S_STAT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [ttt_pkg::CNT_W-1:0] cnt_q, cnt_d, used_q, used_d;
  logic hold_v_q, hold_v_d;
  logic [ttt_pkg::ID_W-1:0] hold_id_q, hold_id_d, sid_q, sid_d;
  logic err_q, err_d;

  logic [ttt_pkg::MODE_W-1:0]   mode_q;
  logic [ttt_pkg::HANDLE_W-1:0] handle_q;
  logic [ttt_pkg::ID_W-1:0]     idx_q;
  logic [ttt_pkg::PER_W-1:0]    per_q, ms_q;

  logic [ttt_pkg::HANDLE_W-1:0] handle_mem [ttt_pkg::MAX_TASKS];
  logic [1:0]                   tstate_mem [ttt_pkg::MAX_TASKS];
  logic [ttt_pkg::CD_W-1:0]     cd_mem     [ttt_pkg::MAX_TASKS];
  logic [ttt_pkg::PER_W-1:0]    rel_mem    [ttt_pkg::MAX_TASKS];

  logic out_valid_q, kind_q, status_q, last_q;
  logic [ttt_pkg::ID_W-1:0] task_id_q;

  logic accept, out_free;
  logic [ttt_pkg::IDX_W-1:0] addr;
  logic [ttt_pkg::HANDLE_W-1:0] rd_handle;
  logic [1:0] rd_state;
  logic [ttt_pkg::CD_W-1:0] rd_cd, rel_cd, blk_res;
  logic [ttt_pkg::PER_W-1:0] rd_rel;

  ttt_pkg::alu_op_e alu_op;
  logic [ttt_pkg::CD_W:0] a33, b33, sum33;
  logic cin, sum_zero, sat, fire, step_ok;

  logic ent_we, hnd_we;
  logic [1:0] wr_state;
  logic [ttt_pkg::CD_W-1:0] wr_cd;
  logic push, push_kind, push_err, push_last;
  logic [ttt_pkg::ID_W-1:0] push_id;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign addr      = (state_q == S_ONE) ? ttt_pkg::IDX_W'(idx_q)
                                        : cnt_q[ttt_pkg::IDX_W-1:0];
  assign rd_handle = handle_mem[addr];
  assign rd_state  = tstate_mem[addr];
  assign rd_cd     = cd_mem[addr];
  assign rd_rel    = rel_mem[addr];
  assign rel_cd    = {1'b0, rd_rel};

  // shared adder
  always_comb begin
    a33 = {rd_cd[ttt_pkg::CD_W-1], rd_cd};
    b33 = ~{2'b00, ms_q};
    cin = 1'b1;
    unique case (alu_op)
      ttt_pkg::ALU_DEC: begin
        b33 = '1;
        cin = 1'b0;
      end
      ttt_pkg::ALU_INC: b33 = '0;
      ttt_pkg::ALU_SUB: ;
      ttt_pkg::ALU_NEG: a33 = '0;
    endcase
    sum33 = a33 + b33 + {{ttt_pkg::CD_W{1'b0}}, cin};
  end

  assign sum_zero = (sum33[ttt_pkg::CD_W-1:0] == '0);
  assign sat      = (alu_op == ttt_pkg::ALU_SUB) &&
                    (sum33[ttt_pkg::CD_W] != sum33[ttt_pkg::CD_W-1]);
  assign blk_res  = sat ? {1'b1, {(ttt_pkg::CD_W-1){1'b0}}} : sum33[ttt_pkg::CD_W-1:0];
  assign fire     = (rd_state == ttt_pkg::TS_READY) && sum_zero;
  assign step_ok  = !(fire && hold_v_q && !out_free);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    used_d    = used_q;
    hold_v_d  = hold_v_q;
    hold_id_d = hold_id_q;
    err_d     = err_q;
    sid_d     = sid_q;
    alu_op    = ttt_pkg::ALU_DEC;
    ent_we    = 1'b0;
    hnd_we    = 1'b0;
    wr_state  = rd_state;
    wr_cd     = rd_cd;
    push      = 1'b0;
    push_kind = 1'b0;
    push_err  = 1'b0;
    push_id   = '0;
    push_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d    = '0;
          hold_v_d = 1'b0;
          err_d    = 1'b0;
          sid_d    = '0;
          unique case (mode_i)
            ttt_pkg::MODE_TICK: state_d = S_WALK;
            ttt_pkg::MODE_ADD:  state_d = S_DUP;
            ttt_pkg::MODE_DALL: state_d = S_DLY;
            ttt_pkg::MODE_DONE,
            ttt_pkg::MODE_TERM,
            ttt_pkg::MODE_RES:  state_d = S_ONE;
            default: begin
              err_d   = 1'b1;
              state_d = S_STAT;
            end
          endcase
        end
      end
      S_WALK: begin
        if (cnt_q == used_q) begin
          state_d = S_FLUSH;
        end else begin
          alu_op = (rd_state == ttt_pkg::TS_READY) ? ttt_pkg::ALU_DEC : ttt_pkg::ALU_INC;
          if (step_ok) begin
            cnt_d = cnt_q + 1'b1;
            if (rd_state == ttt_pkg::TS_READY) begin
              ent_we = 1'b1;
              wr_cd  = fire ? rel_cd : sum33[ttt_pkg::CD_W-1:0];
              if (fire) begin
                push      = hold_v_q;
                push_kind = 1'b1;
                push_id   = hold_id_q;
                hold_v_d  = 1'b1;
                hold_id_d = ttt_pkg::ID_W'(addr);
              end
            end else if (rd_state == ttt_pkg::TS_BLOCKED) begin
              ent_we = 1'b1;
              if (sum_zero) begin
                wr_state = ttt_pkg::TS_READY;
                wr_cd    = rel_cd;
              end else begin
                wr_cd = sum33[ttt_pkg::CD_W-1:0];
              end
            end
          end
        end
      end
      S_FLUSH: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_kind = 1'b1;
          push_id   = hold_id_q;
          push_last = 1'b1;
          hold_v_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end
      S_DUP: begin
        if (cnt_q == used_q) begin
          state_d = S_STAT;
          if (used_q == ttt_pkg::CNT_W'(ttt_pkg::MAX_TASKS)) begin
            err_d = 1'b1;
          end else begin
            hnd_we   = 1'b1;
            ent_we   = 1'b1;
            wr_state = ttt_pkg::TS_READY;
            wr_cd    = {1'b0, per_q};
            sid_d    = ttt_pkg::ID_W'(addr);
            used_d   = used_q + 1'b1;
          end
        end else if (rd_handle == handle_q) begin
          err_d   = 1'b1;
          state_d = S_STAT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DLY: begin
        if (cnt_q == used_q) begin
          state_d = S_STAT;
        end else begin
          alu_op   = rd_cd[ttt_pkg::CD_W-1] ? ttt_pkg::ALU_SUB : ttt_pkg::ALU_NEG;
          ent_we   = 1'b1;
          wr_state = ttt_pkg::TS_BLOCKED;
          wr_cd    = blk_res;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      S_ONE: begin
        state_d = S_STAT;
        if ({1'b0, idx_q} >= (ttt_pkg::ID_W + 1)'(used_q)) begin
          err_d = 1'b1;
        end else begin
          sid_d  = idx_q;
          ent_we = 1'b1;
          alu_op = rd_cd[ttt_pkg::CD_W-1] ? ttt_pkg::ALU_SUB : ttt_pkg::ALU_NEG;
          unique case (mode_q)
            ttt_pkg::MODE_DONE: begin
              wr_state = ttt_pkg::TS_BLOCKED;
              wr_cd    = blk_res;
            end
            ttt_pkg::MODE_TERM: begin
              wr_state = ttt_pkg::TS_TERM;
              wr_cd    = '0;
            end
            default: begin
              wr_state = ttt_pkg::TS_READY;
              wr_cd    = rel_cd;
            end
          endcase
        end
      end
      S_STAT: begin
        if (out_free) begin
          push      = 1'b1;
          push_err  = err_q;
          push_id   = err_q ? '0 : sid_q;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      used_q      <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      used_q   <= used_d;
      hold_v_q <= hold_v_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_id_q <= hold_id_d;
    err_q     <= err_d;
    sid_q     <= sid_d;
    if (accept) begin
      mode_q   <= mode_i;
      handle_q <= task_handle_i;
      idx_q    <= task_index_i;
      per_q    <= period_i;
      ms_q     <= delay_ms_i;
    end
    if (push) begin
      kind_q    <= push_kind;
      status_q  <= push_err;
      task_id_q <= push_id;
      last_q    <= push_last;
    end
    if (ent_we) begin
      tstate_mem[addr] <= wr_state;
      cd_mem[addr]     <= wr_cd;
    end
    if (hnd_we) begin
      handle_mem[addr] <= handle_q;
      rel_mem[addr]    <= per_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign status_o    = status_q;
  assign task_id_o   = task_id_q;
  assign last_o      = last_q;

  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= ttt_pkg::CNT_W'(ttt_pkg::MAX_TASKS))
    else $error("task count beyond table size");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
    else $error("task count moved by more than one");

  a_hold_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> (state_q == S_WALK || state_q == S_FLUSH))
    else $error("pending fire result outside a tick");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> last_o)
    else $error("status result not marked last");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("request accepted without starting work");

endmodule
